// ----- src/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

   // access kinds carried by a request transaction
   typedef enum logic [1:0] {
      MODE_FETCH  = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_STORE  = 2'd2,
      MODE_MODIFY = 2'd3
   } mode_type;

   // lookup outcome codes
   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_MISS  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   // back end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOOK,
      BK_MOD2,
      BK_CLEAR
   } back_state_type;

   // control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 5;
   localparam int WAYS_W       = 4;

   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

   // statistics counters
   localparam int CNT_W = 32;

endpackage

// ----- src/set_assoc_lru_cache_sim.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag store of a set-associative cache with true LRU replacement and
// saturating hit, miss and eviction counters.
// ----------------------------------------------------------------------------
// A load or store reads the set row, then compares and writes back tags and
// ranks, and gives one result; a modify adds a further step and gives two
// results, the second always a hit. Fetches give no result and are dropped by
// the front end. The single-ported set row memory sets the rate. After reset
// the back end clears the valid bits and ranks of all 2^MAX_SET_BITS set rows
// (64 by default), one set row per cycle; requests queue up meanwhile and no
// lookup runs. A two-entry queue lets requests arrive while the back end
// works. A result sits in an output register; the next lookup starts only
// once that result is taken, or in the cycle it is taken. The user must write
// control registers only while no transaction is in flight; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [salc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [ADDR_BITS-1:0]                req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_outcome,
   output logic [salc_pkg::CNT_W-1:0]          rsp_hit_total,
   output logic [salc_pkg::CNT_W-1:0]          rsp_miss_total,
   output logic [salc_pkg::CNT_W-1:0]          rsp_eviction_total,
   output logic                                rsp_last
);

   localparam int TAG_W = ADDR_BITS - 2;
   localparam int SB_W  = $clog2(MAX_SET_BITS + 1);
   localparam int WC_W  = $clog2(MAX_WAYS + 1);
   localparam int Q_W   = 1 + MAX_SET_BITS + TAG_W;

   logic [salc_pkg::SET_BITS_W-1:0]   set_bits_ff;
   logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_ff;
   logic [salc_pkg::WAYS_W-1:0]       ways_ff;
   logic [SB_W-1:0]                   set_bits_eff;
   logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_eff;
   logic [WC_W-1:0]                   ways_eff;

   logic                    q_push, q_full, q_pop, q_not_empty;
   logic [MAX_SET_BITS-1:0] f_set, b_set;
   logic [TAG_W-1:0]        f_tag, b_tag;
   logic                    f_modify, b_modify;
   logic [Q_W-1:0]          q_out;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salc_pkg::SET_BITS_RST;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RST;
         ways_ff       <= salc_pkg::WAYS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS: begin
               set_bits_ff <= salc_pkg::SET_BITS_W'(csr_write_data);
            end
            salc_pkg::CSR_BLOCK_BITS: begin
               block_bits_ff <= csr_write_data;
            end
            salc_pkg::CSR_WAYS: begin
               ways_ff <= salc_pkg::WAYS_W'(csr_write_data);
            end
            default: begin
            end
         endcase
      end
   end

   // clamp geometry to the supported range
   always_comb begin
      if (set_bits_ff == '0) begin
         set_bits_eff = SB_W'(1);
      end else if (set_bits_ff > MAX_SET_BITS) begin
         set_bits_eff = SB_W'(MAX_SET_BITS);
      end else begin
         set_bits_eff = SB_W'(set_bits_ff);
      end
      block_bits_eff = (block_bits_ff == '0) ? 5'd1 : block_bits_ff;
      if (ways_ff == '0) begin
         ways_eff = WC_W'(1);
      end else if (ways_ff > MAX_WAYS) begin
         ways_eff = WC_W'(MAX_WAYS);
      end else begin
         ways_eff = WC_W'(ways_ff);
      end
   end

   salc_front #(
      .ADDR_BITS    (ADDR_BITS),
      .MAX_SET_BITS (MAX_SET_BITS),
      .SB_W         (SB_W),
      .TAG_W        (TAG_W)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_address    (req_address),
      .set_bits_eff   (set_bits_eff),
      .block_bits_eff (block_bits_eff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_set          (f_set),
      .q_tag          (f_tag),
      .q_modify       (f_modify)
   );

   salc_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_modify, f_set, f_tag}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   assign {b_modify, b_set, b_tag} = q_out;

   salc_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .TAG_W        (TAG_W),
      .WC_W         (WC_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_set              (b_set),
      .q_tag              (b_tag),
      .q_modify           (b_modify),
      .q_pop              (q_pop),
      .ways_eff           (ways_eff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   // a fetch never reaches the lookup queue
   a_fetch_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == salc_pkg::MODE_FETCH) |-> !q_push)
      else $error("fetch transaction pushed into lookup queue");

   // hit counter only grows
   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (rsp_hit_total >= $past(rsp_hit_total)))
      else $error("hit counter decreased");

   // every eviction is also a miss
   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_eviction_total <= rsp_miss_total)
      else $error("eviction count exceeds miss count");
`endif

endmodule

// ----- src/salc_front.sv -----
// ----------------------------------------------------------------------------
// salc_front
// Request front end: drops fetches, splits the address into set and tag and
// pushes one lookup transaction into the queue.
// ----------------------------------------------------------------------------
module salc_front #(
   parameter int ADDR_BITS    = 48,
   parameter int MAX_SET_BITS = 6,
   parameter int SB_W         = 3,
   parameter int TAG_W        = 46
) (
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic [ADDR_BITS-1:0]                 req_address,
   input  logic [SB_W-1:0]                      set_bits_eff,
   input  logic [salc_pkg::BLOCK_BITS_W-1:0]    block_bits_eff,
   input  logic                                 q_full,
   output logic                                 q_push,
   output logic [MAX_SET_BITS-1:0]              q_set,
   output logic [TAG_W-1:0]                     q_tag,
   output logic                                 q_modify
);

   logic [5:0]              tag_shamt;
   logic [MAX_SET_BITS-1:0] set_mask;

   // hold the requester only while the queue is full
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full &&
                      (req_mode != salc_pkg::MODE_FETCH);
   assign q_modify  = (req_mode == salc_pkg::MODE_MODIFY);

   // set index sits above the block offset, tag above the set index
   assign set_mask  = ~({MAX_SET_BITS{1'b1}} << set_bits_eff);
   assign q_set     = MAX_SET_BITS'(req_address >> block_bits_eff) & set_mask;
   assign tag_shamt = 6'(block_bits_eff) + 6'(set_bits_eff);
   assign q_tag     = TAG_W'(req_address >> tag_shamt);

endmodule

// ----- src/salc_queue.sv -----
// ----------------------------------------------------------------------------
// salc_queue
// Two-entry queue between the front end and the lookup back end.
// ----------------------------------------------------------------------------
module salc_queue #(
   parameter int WIDTH = 53
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/salc_back.sv -----
// ----------------------------------------------------------------------------
// salc_back
// Lookup back end: reads one set row, compares the ways in use, picks the hit,
// fill or victim way, writes tags and LRU ranks back and reports the result.
// ----------------------------------------------------------------------------
module salc_back #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int TAG_W        = 46,
   parameter int WC_W         = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  logic [MAX_SET_BITS-1:0]       q_set,
   input  logic [TAG_W-1:0]              q_tag,
   input  logic                          q_modify,
   output logic                          q_pop,
   input  logic [WC_W-1:0]               ways_eff,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_outcome,
   output logic [salc_pkg::CNT_W-1:0]    rsp_hit_total,
   output logic [salc_pkg::CNT_W-1:0]    rsp_miss_total,
   output logic [salc_pkg::CNT_W-1:0]    rsp_eviction_total,
   output logic                          rsp_last
);

   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
   localparam logic [MAX_SET_BITS-1:0] LAST_SET = MAX_SET_BITS'(SETS - 1);
   localparam logic [salc_pkg::CNT_W-1:0] CNT_SAT = '1;

   // set rows: valid bits, tags and ranks in memory
   logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_mem   [SETS];
   logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem  [SETS];
   logic [MAX_WAYS-1:0]             valid_mem [SETS];

   logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag_ff;
   logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank_ff;
   logic [MAX_WAYS-1:0]             rd_valid_ff;
   logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;
   logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
   logic [MAX_WAYS-1:0]             row_valid, new_valid;
   logic [MAX_WAYS-1:0]             in_use, hit_vec, free_vec;

   logic [MAX_SET_BITS-1:0]         ent_set_ff;
   logic [TAG_W-1:0]                ent_tag_ff;
   logic                            ent_mod_ff;

   salc_pkg::back_state_type        state_ff, state_in;
   logic [MAX_SET_BITS-1:0]         clr_set_ff, clr_set_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_outcome_ff, rsp_outcome_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [salc_pkg::CNT_W-1:0]      hit_ff, hit_in;
   logic [salc_pkg::CNT_W-1:0]      miss_ff, miss_in;
   logic [salc_pkg::CNT_W-1:0]      evict_ff, evict_in;

   logic                            out_free, wr_en, clr_en, rsp_load;
   logic                            any_hit, any_free, old_valid;
   logic [RANK_W-1:0]               hit_way, free_way, victim, sel_way;
   logic [RANK_W-1:0]               best_rank, old_rank;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign row_valid = rd_valid_ff;

   // tag compare and way selection
   always_comb begin
      hit_way   = '0;
      free_way  = '0;
      victim    = '0;
      best_rank = rd_rank_ff[0];
      for (int v = 0; v < MAX_WAYS; v++) begin
         in_use[v]   = (WC_W'(v) < ways_eff);
         hit_vec[v]  = in_use[v] && row_valid[v] && (rd_tag_ff[v] == ent_tag_ff);
         free_vec[v] = in_use[v] && !row_valid[v];
      end
      for (int v = MAX_WAYS - 1; v >= 0; v--) begin
         if (hit_vec[v]) begin
            hit_way = RANK_W'(v);
         end
         if (free_vec[v]) begin
            free_way = RANK_W'(v);
         end
      end
      // oldest way, ties to the lowest index
      for (int v = 1; v < MAX_WAYS; v++) begin
         if (in_use[v] && rd_rank_ff[v] > best_rank) begin
            best_rank = rd_rank_ff[v];
            victim    = RANK_W'(v);
         end
      end
      any_hit   = |hit_vec;
      any_free  = |free_vec;
      sel_way   = any_hit ? hit_way : (any_free ? free_way : victim);
      old_valid = row_valid[sel_way];
      old_rank  = rd_rank_ff[sel_way];
   end

   // LRU rank update and row write data
   always_comb begin
      for (int v = 0; v < MAX_WAYS; v++) begin
         new_tag[v]  = rd_tag_ff[v];
         new_rank[v] = rd_rank_ff[v];
         if (RANK_W'(v) == sel_way) begin
            new_rank[v] = '0;
            if (!any_hit) begin
               new_tag[v] = ent_tag_ff;
            end
         end else if (in_use[v] && row_valid[v] &&
                      (!old_valid || rd_rank_ff[v] < old_rank) &&
                      rd_rank_ff[v] < RANK_MAX) begin
            new_rank[v] = rd_rank_ff[v] + 1'b1;
         end
      end
      new_valid = row_valid | (MAX_WAYS'(1) << sel_way);
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_set_in     = clr_set_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      clr_en         = 1'b0;
      rsp_load       = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_last_in    = rsp_last_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      evict_in       = evict_ff;
      case (state_ff)
         salc_pkg::BK_CLEAR: begin
            // one set row per cycle after reset
            clr_en     = 1'b1;
            clr_set_in = clr_set_ff + 1'b1;
            if (clr_set_ff == LAST_SET) begin
               state_in = salc_pkg::BK_IDLE;
            end
         end
         salc_pkg::BK_IDLE: begin
            if (q_not_empty && out_free) begin
               q_pop    = 1'b1;
               state_in = salc_pkg::BK_LOOK;
            end
         end
         salc_pkg::BK_LOOK: begin
            wr_en       = 1'b1;
            rsp_load    = 1'b1;
            rsp_last_in = !ent_mod_ff;
            if (any_hit) begin
               rsp_outcome_in = salc_pkg::OUT_HIT;
               hit_in = (hit_ff == CNT_SAT) ? hit_ff : hit_ff + 1'b1;
            end else begin
               miss_in = (miss_ff == CNT_SAT) ? miss_ff : miss_ff + 1'b1;
               if (any_free) begin
                  rsp_outcome_in = salc_pkg::OUT_MISS;
               end else begin
                  rsp_outcome_in = salc_pkg::OUT_EVICT;
                  evict_in = (evict_ff == CNT_SAT) ? evict_ff : evict_ff + 1'b1;
               end
            end
            state_in = ent_mod_ff ? salc_pkg::BK_MOD2 : salc_pkg::BK_IDLE;
         end
         salc_pkg::BK_MOD2: begin
            // store half of a modify hits the line just touched; ranks stay
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_outcome_in = salc_pkg::OUT_HIT;
               hit_in   = (hit_ff == CNT_SAT) ? hit_ff : hit_ff + 1'b1;
               state_in = salc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = salc_pkg::BK_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::BK_CLEAR;
         clr_set_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_set_ff   <= clr_set_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
      end
   end

   // transaction and result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ent_set_ff <= q_set;
         ent_tag_ff <= q_tag;
         ent_mod_ff <= q_modify;
      end
      if (rsp_load) begin
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   // set row memory, registered read
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_tag_ff   <= tag_mem[q_set];
         rd_rank_ff  <= rank_mem[q_set];
         rd_valid_ff <= valid_mem[q_set];
      end
      if (clr_en) begin
         rank_mem[clr_set_ff]  <= '0;
         valid_mem[clr_set_ff] <= '0;
      end else if (wr_en) begin
         tag_mem[ent_set_ff]   <= new_tag;
         rank_mem[ent_set_ff]  <= new_rank;
         valid_mem[ent_set_ff] <= new_valid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_hit_total      = hit_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_eviction_total = evict_ff;

endmodule

// ----- dv/set_assoc_lru_cache_sim_tb.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_tb
// Self-checking testbench of the set-associative LRU cache tag store. A
// predictor in the testbench tracks valid bits, tags, recency ranks and the
// hit, miss and eviction counters. Every response transaction is checked
// field by field against the oldest predicted lookup. The run covers directed
// corners, geometry extremes, randomized geometry phases, back pressure, and
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_tb;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int ADDR_BITS    = 48;
   localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int STALL_LIMIT  = 3000;
   localparam int CNT_W        = salc_pkg::CNT_W;
   localparam int CSR_IDX_W    = salc_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W   = salc_pkg::CSR_DATA_W;

   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      salc_pkg::outcome_type outcome;
      logic [CNT_W-1:0]      hit_total;
      logic [CNT_W-1:0]      miss_total;
      logic [CNT_W-1:0]      eviction_total;
      logic                  last;
   } lookup_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_mode;
   logic [ADDR_BITS-1:0]  req_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_outcome;
   logic [CNT_W-1:0]      rsp_hit_total;
   logic [CNT_W-1:0]      rsp_miss_total;
   logic [CNT_W-1:0]      rsp_eviction_total;
   logic                  rsp_last;

   // predictor state
   logic                                  line_ok [NUM_LINES];
   logic [ADDR_BITS-1:0]                  line_tag_copy [NUM_LINES];
   int unsigned                           line_rank [NUM_LINES];
   logic [CNT_W-1:0]                      hits, misses, evictions;
   logic [salc_pkg::SET_BITS_W-1:0]       cfg_set_bits;
   logic [salc_pkg::BLOCK_BITS_W-1:0]     cfg_block_bits;
   logic [salc_pkg::WAYS_W-1:0]           cfg_ways;

   lookup_result_type pending_lookups [$];

   int  mismatches;
   int  accesses_sent;
   int  lookups_checked;
   int  phases_run;
   int  idle_cycles;
   bit  idle_enable;
   int  rsp_hold_cycles;

   set_assoc_lru_cache_sim dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_outcome        (rsp_outcome),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .rsp_last           (rsp_last)
   );

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // effective geometry after range clamping
   function automatic int eff_set_bits();
      if (cfg_set_bits < 1) return 1;
      if (cfg_set_bits > MAX_SET_BITS) return MAX_SET_BITS;
      return cfg_set_bits;
   endfunction

   function automatic int eff_block_bits();
      return (cfg_block_bits < 1) ? 1 : cfg_block_bits;
   endfunction

   function automatic int eff_ways();
      if (cfg_ways < 1) return 1;
      if (cfg_ways > MAX_WAYS) return MAX_WAYS;
      return cfg_ways;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1;
   endfunction

   // mark way w most recent, aging younger valid ways
   task automatic promote_way(input int base, input int nways, input int w);
      int old_rank;
      old_rank = line_ok[base + w] ? line_rank[base + w] : 1000;
      for (int v = 0; v < nways; v++) begin
         if (v != w && line_ok[base + v] && line_rank[base + v] < old_rank
             && line_rank[base + v] < MAX_WAYS - 1)
            line_rank[base + v]++;
      end
      line_rank[base + w] = 0;
      line_ok[base + w]   = 1'b1;
   endtask

   // one tag lookup with fill or eviction on miss
   task automatic tag_lookup(input logic [ADDR_BITS-1:0] addr,
                             output salc_pkg::outcome_type oc);
      int sb, bb, nways, set_idx, base, victim, best;
      logic [ADDR_BITS-1:0] tag;
      sb      = eff_set_bits();
      bb      = eff_block_bits();
      nways   = eff_ways();
      set_idx = int'((addr >> bb) & ((48'd1 << sb) - 1));
      tag     = addr >> (bb + sb);
      base    = set_idx * MAX_WAYS;
      victim  = -1;
      for (int w = 0; w < nways; w++) begin
         if (victim < 0 && line_ok[base + w] && line_tag_copy[base + w] == tag)
            victim = w;
      end
      if (victim >= 0) begin
         promote_way(base, nways, victim);
         hits = sat_inc(hits);
         oc   = salc_pkg::OUT_HIT;
         return;
      end
      misses = sat_inc(misses);
      for (int w = 0; w < nways; w++) begin
         if (victim < 0 && !line_ok[base + w])
            victim = w;
      end
      if (victim >= 0) begin
         line_tag_copy[base + victim] = tag;
         promote_way(base, nways, victim);
         oc = salc_pkg::OUT_MISS;
         return;
      end
      victim = 0;
      best   = line_rank[base];
      for (int w = 1; w < nways; w++) begin
         if (line_rank[base + w] > best) begin
            best   = line_rank[base + w];
            victim = w;
         end
      end
      line_tag_copy[base + victim] = tag;
      promote_way(base, nways, victim);
      evictions = sat_inc(evictions);
      oc = salc_pkg::OUT_EVICT;
   endtask

   task automatic push_lookup(input salc_pkg::outcome_type oc, input logic last);
      lookup_result_type r;
      r.outcome        = oc;
      r.hit_total      = hits;
      r.miss_total     = misses;
      r.eviction_total = evictions;
      r.last           = last;
      pending_lookups.push_back(r);
   endtask

   // predict the lookups caused by one access
   task automatic predict_access(input salc_pkg::mode_type mode,
                                 input logic [ADDR_BITS-1:0] addr);
      salc_pkg::outcome_type oc;
      if (mode == salc_pkg::MODE_FETCH) return;
      tag_lookup(addr, oc);
      push_lookup(oc, mode != salc_pkg::MODE_MODIFY);
      if (mode == salc_pkg::MODE_MODIFY) begin
         tag_lookup(addr, oc);
         push_lookup(oc, 1'b1);
      end
   endtask

   // send one access transaction; valid stays high for a following item
   task automatic send_access(input salc_pkg::mode_type mode,
                              input logic [ADDR_BITS-1:0] addr);
      int gap;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_access(mode, addr);
      accesses_sent++;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let the block go idle: all lookups out, then a short settle for fetches
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      case (idx)
         salc_pkg::CSR_SET_BITS:   cfg_set_bits   = data[salc_pkg::SET_BITS_W-1:0];
         salc_pkg::CSR_BLOCK_BITS: cfg_block_bits = data[salc_pkg::BLOCK_BITS_W-1:0];
         salc_pkg::CSR_WAYS:       cfg_ways       = data[salc_pkg::WAYS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int sb, input int bb, input int nw);
      write_csr(salc_pkg::CSR_SET_BITS, CSR_DATA_W'(sb));
      write_csr(salc_pkg::CSR_BLOCK_BITS, CSR_DATA_W'(bb));
      write_csr(salc_pkg::CSR_WAYS, CSR_DATA_W'(nw));
      phases_run++;
   endtask

   // address from a small pool of tags and sets so that hits and evictions occur
   function automatic logic [ADDR_BITS-1:0] pick_address();
      int sb, bb, set_idx;
      logic [ADDR_BITS-1:0] a;
      if ($urandom_range(0, 4) == 0)
         return ADDR_BITS'({$urandom, $urandom});
      sb      = eff_set_bits();
      bb      = eff_block_bits();
      set_idx = $urandom_range(0, ((1 << sb) - 1) < 3 ? (1 << sb) - 1 : 3);
      a = (ADDR_BITS'($urandom_range(0, 11)) << (bb + sb))
          | (ADDR_BITS'(set_idx) << bb)
          | (ADDR_BITS'({$urandom, $urandom}) & ((ADDR_BITS'(1) << bb) - 1));
      return a;
   endfunction

   function automatic salc_pkg::mode_type pick_mode();
      return salc_pkg::mode_type'($urandom_range(0, 3));
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_geometry();
      // reset geometry: 16 sets, 16-byte blocks, direct mapped
      send_access(salc_pkg::MODE_LOAD, 48'h0);
      send_access(salc_pkg::MODE_LOAD, 48'h8);
      send_access(salc_pkg::MODE_STORE, 48'hFFFF_FFFF_FFFF);
      send_access(salc_pkg::MODE_FETCH, 48'h10);
      send_access(salc_pkg::MODE_MODIFY, 48'h100);
      send_access(salc_pkg::MODE_MODIFY, 48'h0);
      send_access(salc_pkg::MODE_LOAD, 48'h100);
      send_access(salc_pkg::MODE_STORE, 48'h5555_5555_5555);
      send_access(salc_pkg::MODE_LOAD, 48'hAAAA_AAAA_AAAA);
      drain();
   endtask

   task automatic test_geometry_extremes();
      // set bits, block bits and ways zero are raised, above-range set bits and ways saturate
      set_geometry(0, 0, 0);
      send_access(salc_pkg::MODE_LOAD, 48'h2);
      send_access(salc_pkg::MODE_LOAD, 48'h6);
      send_access(salc_pkg::MODE_MODIFY, 48'h1_0000);
      drain();
      set_geometry(7, 31, 15);
      for (int i = 0; i < 10; i++)
         send_access(salc_pkg::MODE_LOAD, ADDR_BITS'(i) << 37);
      send_access(salc_pkg::MODE_LOAD, 48'h0);
      send_access(salc_pkg::MODE_STORE, 48'h1F_FFFF_FFFF);
      drain();
      // write to the unused register index is ignored
      write_csr(CSR_UNUSED, 5'd1);
      send_access(salc_pkg::MODE_LOAD, 48'h20_0000_0000);
      drain();
      // shrink ways after use: upper ways kept but not looked up
      set_geometry(6, 16, 2);
      for (int i = 0; i < 4; i++)
         send_access(salc_pkg::MODE_MODIFY, ADDR_BITS'(i) << 22);
      drain();
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         set_geometry($urandom_range(0, 7),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 8),
                      $urandom_range(0, 15));
         for (int i = 0; i < per_phase; i++)
            send_access(pick_mode(), pick_address());
         drain();
      end
   endtask

   task automatic test_back_pressure();
      // receiver holds off while the sender keeps offering modifies
      set_geometry(2, 4, 4);
      rsp_hold_cycles = 200;
      for (int i = 0; i < 24; i++)
         send_access(salc_pkg::MODE_MODIFY, pick_address());
      drain();
   endtask

   task automatic test_no_idle();
      idle_enable = 1'b0;
      set_geometry(3, 5, 8);
      for (int i = 0; i < 150; i++)
         send_access(pick_mode(), pick_address());
      drain();
   endtask

   // response checker and receiver stall control
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         lookups_checked++;
         if (pending_lookups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response transaction: outcome %0d last %0d",
                        rsp_outcome, rsp_last);
         end else begin
            exp_r = pending_lookups.pop_front();
            if (rsp_outcome !== exp_r.outcome || rsp_hit_total !== exp_r.hit_total
                || rsp_miss_total !== exp_r.miss_total
                || rsp_eviction_total !== exp_r.eviction_total
                || rsp_last !== exp_r.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp out %0d h %0d m %0d e %0d last %0d",
                            " / got out %0d h %0d m %0d e %0d last %0d"},
                           exp_r.outcome, exp_r.hit_total, exp_r.miss_total,
                           exp_r.eviction_total, exp_r.last, rsp_outcome,
                           rsp_hit_total, rsp_miss_total, rsp_eviction_total,
                           rsp_last);
            end
         end
      end
      // next cycle's stall
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         idle_cycles <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no transaction accepted
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("watchdog expired with %0d lookups pending", pending_lookups.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_write_data  = '0;
      req_valid       = 1'b0;
      req_mode        = '0;
      req_address     = '0;
      rsp_stall       = 1'b0;
      mismatches      = 0;
      accesses_sent   = 0;
      lookups_checked = 0;
      phases_run      = 0;
      idle_cycles     = 0;
      rsp_hold_cycles = 0;
      idle_enable     = 1'b1;
      hits            = '0;
      misses          = '0;
      evictions       = '0;
      cfg_set_bits    = salc_pkg::SET_BITS_RST;
      cfg_block_bits  = salc_pkg::BLOCK_BITS_RST;
      cfg_ways        = salc_pkg::WAYS_RST;
      for (int i = 0; i < NUM_LINES; i++) begin
         line_ok[i]       = 1'b0;
         line_tag_copy[i] = '0;
         line_rank[i]     = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_geometry_extremes();
      test_random_phases(8, 180);
      test_back_pressure();
      test_random_phases(1, 40);
      test_no_idle();

      repeat (20) @(posedge clock);
      $display("covered %0d accesses, %0d lookups checked over %0d geometry settings",
               accesses_sent, lookups_checked, phases_run);
      $display("hits %0d misses %0d evictions %0d, mismatches %0d",
               hits, misses, evictions, mismatches);
      if (mismatches == 0 && pending_lookups.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
